### hw/rtl/status_led_blink_code_generator_assert.svh
// ----------------------------------------------------------------------------
// Status LED blink-code generator: assertion macros
// Shared property wrappers for the checkers of this block.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_BLINK_CODE_GENERATOR_ASSERT_SVH
`define STATUS_LED_BLINK_CODE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLBCG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slbcg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLBCG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slbcg assertion failed");

`endif

### hw/rtl/slbcg_pkg.sv
// ----------------------------------------------------------------------------
// Status LED blink-code generator package
// Transaction types, action and mode codes, register indexes and widths.
// ----------------------------------------------------------------------------
package slbcg_pkg;

  localparam int DefaultGapTicks = 200;
  localparam int DefaultPhaseWidth = 17;

  // Number of burst patterns, one for each flash count from one to five.
  localparam int NumPatterns = 5;
  // Width that holds the longest burst cycle: 5*255 + 4*255 + 65535.
  localparam int CycW = 17;
  // Width that holds the end of the last flash: 4*510 + 255.
  localparam int StartW = 12;
  localparam int FastW = 9;

  localparam logic [7:0] RstFlashOn = 8'd12;
  localparam logic [7:0] RstFlashOff = 8'd12;
  localparam logic [15:0] RstBurstGap = 16'd200;
  localparam logic [15:0] RstErrorHold = 16'd500;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_SET_MODE    = 3'd1,
    ACT_SET_FAULT   = 3'd2,
    ACT_NET_ERROR   = 3'd3,
    ACT_WRITE_FAULT = 3'd4,
    ACT_CLEAR_FAULT = 3'd5,
    ACT_CLEAR_ALL   = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_ERROR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_FLASH_ON   = 2'd0,
    REG_FLASH_OFF  = 2'd1,
    REG_BURST_GAP  = 2'd2,
    REG_ERROR_HOLD = 2'd3
  } cfg_reg_e;

  localparam logic [2:0] FaultReady         = 3'd0;
  localparam logic [2:0] FaultBusUnconfig   = 3'd1;
  localparam logic [2:0] FaultNodeMissing   = 3'd2;
  localparam logic [2:0] FaultWriteFailed   = 3'd3;
  localparam logic [2:0] FaultGadgetMissing = 3'd4;
  localparam logic [2:0] FaultDegraded      = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] mode_value;
    logic [2:0] fault_value;
    logic       bus_configured;
  } in_item_t;

  typedef struct packed {
    logic primary_led;
    logic secondary_led;
  } out_item_t;

endpackage

### hw/rtl/status_led_blink_code_generator.sv
// ----------------------------------------------------------------------------
// Status LED blink-code generator
// Drives a network status LED and a fault code LED from event and tick
// transactions, with programmable flash, gap and error hold timing.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one transaction per event or per 10 ms
// tick. Event transactions change the network mode or the fault code and
// give no result. Each tick transaction gives exactly one result on the
// output channel, holding the two LED levels that apply to that tick.
// The result is registered: a tick accepted in one cycle shows its result
// in the next. Throughput is one transaction per cycle while results are
// taken; the single result register sets this, and the block takes a new transaction
// whenever that register is empty or is being emptied in the same cycle.
// If the receiver stalls with a result waiting, ready drops until the
// result is taken, and the result stays unchanged meanwhile.
// Reset loads the default timing (12 ticks on, 12 off, 200 gap, 500 hold),
// idle mode, the ready fault code, and all phase counters at zero. The
// configuration port writes one register a cycle; writing the flash or gap
// timing restarts every phase counter.
// ----------------------------------------------------------------------------
module status_led_blink_code_generator
  import slbcg_pkg::*;
#(
  parameter int DEFAULT_GAP_TICKS = DefaultGapTicks,
  parameter int PHASE_WIDTH       = DefaultPhaseWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Compare width wide enough for both a phase value and a cycle length.
  localparam int CmpW = (PHASE_WIDTH > CycW) ? PHASE_WIDTH + 1 : CycW + 1;

  // Timing registers.
  logic [7:0]  flash_on_q, flash_on_d;
  logic [7:0]  flash_off_q, flash_off_d;
  logic [15:0] burst_gap_q, burst_gap_d;
  logic [15:0] error_hold_q, error_hold_d;

  // Block state.
  mode_e                  mode_q, mode_d;
  logic [2:0]             fault_q, fault_d;
  logic                   armed_q, armed_d;
  logic [15:0]            remain_q, remain_d;
  logic [PHASE_WIDTH-1:0] burst_phase_q [NumPatterns];
  logic [PHASE_WIDTH-1:0] burst_phase_d [NumPatterns];
  logic [FastW-1:0]       fast_phase_q, fast_phase_d;

  // Result register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  // Derived timing and pattern decode.
  logic [FastW-1:0]       period;
  logic [15:0]            gap_eff;
  logic [CycW-1:0]        cycle_len [NumPatterns];
  logic [StartW-1:0]      flash_start [NumPatterns];
  logic [StartW-1:0]      flash_end [NumPatterns];
  logic [NumPatterns-1:0] burst_lit;
  logic [PHASE_WIDTH-1:0] phase_inc [NumPatterns];
  logic [FastW-1:0]       fast_inc;
  mode_e                  shown_mode;
  logic [2:0]             shown_fault;
  logic                   primary;
  logic                   secondary;
  logic                   accept;
  in_item_t               item;
  logic                   restart;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign item        = in_data_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign period  = {1'b0, flash_on_q} + {1'b0, flash_off_q};
  assign gap_eff = (burst_gap_q != 16'd0) ? burst_gap_q : 16'(DEFAULT_GAP_TICKS);

  // Flash k of any burst is lit for phases in [k*period, k*period + on).
  // A burst of n flashes lasts n*on + (n-1)*off + gap ticks.
  always_comb begin
    for (int k = 0; k < NumPatterns; k++) begin
      flash_start[k] = StartW'(period) * StartW'(k);
      flash_end[k]   = flash_start[k] + StartW'(flash_on_q);
      cycle_len[k]   = CycW'(flash_on_q) * CycW'(k + 1) + CycW'(flash_off_q) * CycW'(k)
                     + CycW'(gap_eff);
    end
  end

  // The counter of pattern i is lit when its phase falls inside any of
  // its first i+1 flashes. With no lit time no flash ever shows.
  always_comb begin
    for (int i = 0; i < NumPatterns; i++) begin
      burst_lit[i] = 1'b0;
      for (int k = 0; k < NumPatterns; k++) begin
        if (k <= i &&
            CmpW'(burst_phase_q[i]) >= CmpW'(flash_start[k]) &&
            CmpW'(burst_phase_q[i]) <  CmpW'(flash_end[k])) begin
          burst_lit[i] = 1'b1;
        end
      end
      if (flash_on_q == 8'd0) begin
        burst_lit[i] = 1'b0;
      end
    end
  end

  // An expired latched error is shown as idle, while the stored mode stays.
  always_comb begin
    shown_mode = mode_q;
    if (mode_q == MODE_ERROR && armed_q && remain_q == 16'd0) begin
      shown_mode = MODE_IDLE;
    end
    case (shown_mode)
      MODE_ACTIVE: primary = 1'b1;
      MODE_ERROR:  primary = (flash_on_q != 8'd0) && (fast_phase_q < {1'b0, flash_on_q});
      default:     primary = burst_lit[2];
    endcase
  end

  // An unconfigured bus forces a single flash, unless the gadget is missing.
  always_comb begin
    shown_fault = fault_q;
    if (fault_q != FaultGadgetMissing && !item.bus_configured) begin
      shown_fault = FaultBusUnconfig;
    end
    case (shown_fault)
      FaultBusUnconfig:   secondary = burst_lit[0];
      FaultNodeMissing:   secondary = burst_lit[1];
      FaultWriteFailed:   secondary = burst_lit[2];
      FaultGadgetMissing: secondary = burst_lit[3];
      FaultDegraded:      secondary = burst_lit[4];
      default:            secondary = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NumPatterns; i++) begin
      phase_inc[i] = burst_phase_q[i] + PHASE_WIDTH'(1);
    end
    fast_inc = fast_phase_q + FastW'(1);
  end

  // Configuration writes and transaction processing.
  always_comb begin
    flash_on_d   = flash_on_q;
    flash_off_d  = flash_off_q;
    burst_gap_d  = burst_gap_q;
    error_hold_d = error_hold_q;
    mode_d       = mode_q;
    fault_d      = fault_q;
    armed_d      = armed_q;
    remain_d     = remain_q;
    burst_phase_d = burst_phase_q;
    fast_phase_d = fast_phase_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    restart      = 1'b0;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FLASH_ON: begin
          flash_on_d = cfg_data_i[7:0];
          restart    = 1'b1;
        end
        REG_FLASH_OFF: begin
          flash_off_d = cfg_data_i[7:0];
          restart     = 1'b1;
        end
        REG_BURST_GAP: begin
          burst_gap_d = cfg_data_i;
          restart     = 1'b1;
        end
        REG_ERROR_HOLD: error_hold_d = cfg_data_i;
        default: ;
      endcase
    end

    if (accept) begin
      case (action_e'(item.action))
        ACT_TICK: begin
          out_valid_d = 1'b1;
          out_data_d.primary_led   = primary;
          out_data_d.secondary_led = secondary;
          for (int i = 0; i < NumPatterns; i++) begin
            if (CmpW'(phase_inc[i]) >= CmpW'(cycle_len[i])) begin
              burst_phase_d[i] = '0;
            end else begin
              burst_phase_d[i] = phase_inc[i];
            end
          end
          if (period == '0 || fast_inc >= period) begin
            fast_phase_d = '0;
          end else begin
            fast_phase_d = fast_inc;
          end
          if (remain_q != 16'd0) begin
            remain_d = remain_q - 16'd1;
          end
        end
        ACT_SET_MODE: begin
          // The unused mode code is ignored.
          if (item.mode_value <= MODE_ERROR) begin
            mode_d = mode_e'(item.mode_value);
            if (mode_e'(item.mode_value) != MODE_ERROR) begin
              armed_d  = 1'b0;
              remain_d = 16'd0;
            end
          end
        end
        ACT_SET_FAULT: begin
          if (item.fault_value <= FaultDegraded) begin
            fault_d = item.fault_value;
          end
        end
        ACT_NET_ERROR: begin
          mode_d   = MODE_ERROR;
          armed_d  = 1'b1;
          remain_d = error_hold_q;
        end
        ACT_WRITE_FAULT: fault_d = FaultWriteFailed;
        ACT_CLEAR_FAULT: fault_d = FaultReady;
        ACT_CLEAR_ALL: begin
          mode_d   = MODE_IDLE;
          fault_d  = FaultReady;
          armed_d  = 1'b0;
          remain_d = 16'd0;
        end
        default: ;
      endcase
    end

    if (restart) begin
      for (int i = 0; i < NumPatterns; i++) begin
        burst_phase_d[i] = '0;
      end
      fast_phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_on_q   <= RstFlashOn;
      flash_off_q  <= RstFlashOff;
      burst_gap_q  <= RstBurstGap;
      error_hold_q <= RstErrorHold;
      mode_q       <= MODE_IDLE;
      fault_q      <= FaultReady;
      armed_q      <= 1'b0;
      remain_q     <= 16'd0;
      for (int i = 0; i < NumPatterns; i++) begin
        burst_phase_q[i] <= '0;
      end
      fast_phase_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      flash_on_q    <= flash_on_d;
      flash_off_q   <= flash_off_d;
      burst_gap_q   <= burst_gap_d;
      error_hold_q  <= error_hold_d;
      mode_q        <= mode_d;
      fault_q       <= fault_d;
      armed_q       <= armed_d;
      remain_q      <= remain_d;
      burst_phase_q <= burst_phase_d;
      fast_phase_q  <= fast_phase_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

### hw/rtl/slbcg_checker.sv
// ----------------------------------------------------------------------------
// Status LED blink-code generator checker
// Port-level checks on transaction flow and result behaviour.
// ----------------------------------------------------------------------------
`include "status_led_blink_code_generator_assert.svh"

module slbcg_checker
  import slbcg_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input in_item_t  in_data_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result is held unchanged.
  `SLBCG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
                    out_valid_i && $stable(out_data_i))

  // The block is always ready while no result is pending.
  `SLBCG_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // Every accepted tick shows a result in the next cycle.
  `SLBCG_ASSERT_NXT(a_tick_result, clk_i, rst_ni,
                    in_acc && in_data_i.action == ACT_TICK, out_valid_i)

  // An event transaction never creates a result of its own.
  `SLBCG_ASSERT_NXT(a_event_silent, clk_i, rst_ni,
                    in_acc && in_data_i.action != ACT_TICK && !out_stall, !out_valid_i)

  // Active mode lights the network LED steadily.
  `SLBCG_ASSERT_NXT(a_active_lit, clk_i, rst_ni,
                    in_acc && in_data_i.action == ACT_SET_MODE &&
                    in_data_i.mode_value == MODE_ACTIVE ##1
                    in_acc && in_data_i.action == ACT_TICK,
                    out_data_i.primary_led)

endmodule

bind status_led_blink_code_generator slbcg_checker u_slbcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
